@@ design/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Types and constants shared by the solenoid strike scheduler and its checker.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int SCAN_BYTES = 28;

    localparam logic [7:0] FIRST_BYTE_MASK = 8'hf0;
    localparam logic [7:0] COUNT_MAX       = 8'hff;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SCAN  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_PAUSE  = 2'd1,
        REQ_RESUME = 2'd2
    } t_scan_req;

    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_ON_TIME  = 2'd1,
        CFG_RECOVERY = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_action    action;
        logic [4:0] byte_index;
        logic [7:0] previous_keys;
        logic [7:0] current_keys;
    } t_in_item;

    typedef struct packed {
        logic       solenoid_drive;
        t_scan_req  scan_request;
        logic [7:0] pending_strikes;
    } t_out_item;

endpackage

@@ design/solenoid_strike_scheduler.sv @@
// ----------------------------------------------------------------------------
// solenoid_strike_scheduler
// Queues key-click strikes from scan bytes and times the solenoid per tick.
// ----------------------------------------------------------------------------
// Every accepted transaction gives exactly one result transaction on the next
// cycle. A new transaction is taken in every cycle while the result register
// is empty or being drained, so the block sustains one transaction per clock;
// the single result register is the only stage. Configuration writes are
// always ready and registered; a transaction taken with a write sees old ones.
module solenoid_strike_scheduler
    import sss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,

    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_index i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_enable;
    logic [7:0] r_on_time;
    logic [7:0] r_recovery;

    logic [7:0] r_ticks;
    logic [7:0] r_queue;
    logic       r_level;

    logic      r_out_valid;
    t_out_item r_out_data;

    logic [7:0] n_ticks;
    logic [7:0] n_queue;
    logic       n_level;
    t_scan_req  n_req;

    logic       in_fire;
    logic [7:0] ticks_inc;
    logic [7:0] fresh;
    logic [3:0] fresh_count;
    logic [8:0] queue_sum;
    logic       byte_in_range;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign ticks_inc     = (r_ticks != COUNT_MAX) ? r_ticks + 8'd1 : r_ticks;
    assign byte_in_range = {1'b0, i_in_data.byte_index} < 6'(SCAN_BYTES);

    always_comb begin
        fresh = i_in_data.current_keys & ~i_in_data.previous_keys;
        if (i_in_data.byte_index == 5'd0) begin
            fresh = fresh & FIRST_BYTE_MASK;
        end
        fresh_count = 4'd0;
        for (int b = 0; b < 8; b++) begin
            fresh_count = fresh_count + {3'd0, fresh[b]};
        end
        queue_sum = {1'b0, r_queue} + {5'd0, fresh_count};
    end

    always_comb begin
        n_ticks = r_ticks;
        n_queue = r_queue;
        n_level = r_level;
        n_req   = REQ_NONE;
        case (i_in_data.action)
            ACT_TICK: begin
                n_ticks = ticks_inc;
                if (r_enable) begin
                    if (ticks_inc == r_on_time) begin
                        n_level = 1'b0;
                    end else if (ticks_inc == r_recovery) begin
                        n_req = REQ_RESUME;
                    end else if (r_queue != 8'd0 && ticks_inc > r_recovery) begin
                        n_ticks = 8'd0;
                        n_queue = r_queue - 8'd1;
                        n_level = 1'b1;
                        n_req   = REQ_PAUSE;
                    end
                end
            end
            ACT_SCAN: begin
                if (r_enable && byte_in_range) begin
                    n_queue = queue_sum[8] ? COUNT_MAX : queue_sum[7:0];
                end
            end
            ACT_CLEAR: begin
                n_ticks = 8'd0;
                n_queue = 8'd0;
                n_level = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_on_time  <= 8'd0;
            r_recovery <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_ON_TIME:  r_on_time  <= i_cfg_data;
                CFG_RECOVERY: r_recovery <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= 8'd0;
            r_queue     <= 8'd0;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ticks     <= n_ticks;
                r_queue     <= n_queue;
                r_level     <= n_level;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data.solenoid_drive  <= n_level;
            r_out_data.scan_request    <= n_req;
            r_out_data.pending_strikes <= n_queue;
        end
    end

endmodule

@@ design/sss_checker.sv @@
// ----------------------------------------------------------------------------
// sss_checker
// Port-level checks for the solenoid strike scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sss_checker
    import sss_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_item   i_in_data,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out_data
);

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // clear leaves everything empty
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.action == ACT_CLEAR |=>
            o_out_valid && o_out_data.pending_strikes == 8'd0
            && !o_out_data.solenoid_drive && o_out_data.scan_request == REQ_NONE)
        else $error("clear did not empty state");

    // only ticks raise scan requests
    a_req_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.action != ACT_TICK |=>
            o_out_data.scan_request == REQ_NONE)
        else $error("scan request on non-tick transaction");

    // a pause always comes with the solenoid firing
    a_pause_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scan_request == REQ_PAUSE |->
            o_out_data.solenoid_drive)
        else $error("pause without solenoid drive");

endmodule

bind solenoid_strike_scheduler sss_checker u_sss_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for solenoid_strike_scheduler. A predictor tracks
// the strike queue, the tick counter and the drive level. It computes each
// result when its transaction is accepted, and a checker compares every
// result transaction with the oldest prediction. Directed cases come first,
// then saturation runs, a back-to-back stretch, an output stall and random
// phases under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import sss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 200;
    localparam int         STALL_LIMIT = 4000;
    localparam int         TAIL_CYCLES = 10;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index = CFG_ENABLE;
    logic [7:0] i_cfg_data  = '0;

    // predictor state and register copies
    logic       cfg_enable   = 1'b0;
    logic [7:0] cfg_on_time  = '0;
    logic [7:0] cfg_recovery = '0;
    logic [7:0] tick_count   = '0;
    logic [7:0] strike_count = '0;
    logic       drive_level  = 1'b0;

    t_out_item expected_results[$];
    int        mismatches   = 0;
    int        stall_cycles = 0;
    bit        tx_gaps_on   = 1'b1;
    bit        rx_idle_on   = 1'b1;
    int        hold_tickets = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;

    solenoid_strike_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_item predict_strike_result(t_in_item item);
        t_out_item  res;
        logic [7:0] fresh;
        int         total;
        res.scan_request = REQ_NONE;
        case (item.action)
            ACT_TICK: begin
                if (tick_count != COUNT_MAX) tick_count = tick_count + 8'd1;
                if (cfg_enable) begin
                    if (tick_count == cfg_on_time) begin
                        drive_level = 1'b0;
                    end else if (tick_count == cfg_recovery) begin
                        res.scan_request = REQ_RESUME;
                    end else if (strike_count != 0 && tick_count > cfg_recovery) begin
                        tick_count       = '0;
                        strike_count     = strike_count - 8'd1;
                        drive_level      = 1'b1;
                        res.scan_request = REQ_PAUSE;
                    end
                end
            end
            ACT_SCAN: begin
                if (cfg_enable && item.byte_index < SCAN_BYTES) begin
                    fresh = item.current_keys & ~item.previous_keys;
                    if (item.byte_index == 0) fresh = fresh & FIRST_BYTE_MASK;
                    total = strike_count + $countones(fresh);
                    strike_count = (total > COUNT_MAX) ? COUNT_MAX : total[7:0];
                end
            end
            ACT_CLEAR: begin
                tick_count   = '0;
                strike_count = '0;
                drive_level  = 1'b0;
            end
            default: ;
        endcase
        res.solenoid_drive  = drive_level;
        res.pending_strikes = strike_count;
        return res;
    endfunction

    function automatic t_in_item make_item(t_action act, logic [4:0] idx,
                                           logic [7:0] prev, logic [7:0] curr);
        t_in_item item;
        item.action        = act;
        item.byte_index    = idx;
        item.previous_keys = prev;
        item.current_keys  = curr;
        return item;
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       pick;
        pick = $urandom_range(0, 99);
        item.byte_index    = ($urandom_range(0, 99) < 85) ?
                             5'($urandom_range(0, SCAN_BYTES - 1)) :
                             5'($urandom_range(SCAN_BYTES, 31));
        item.previous_keys = 8'($urandom);
        item.current_keys  = 8'($urandom);
        if (pick < 72)      item.action = ACT_TICK;
        else if (pick < 94) item.action = ACT_SCAN;
        else if (pick < 97) item.action = ACT_CLEAR;
        else                item.action = t_action'(ACT_UNUSED);
        return item;
    endfunction

    task automatic send_item(t_in_item item);
        @(negedge i_clk);
        while (tx_gaps_on && $urandom_range(0, 99) < 28) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_strike_result(item));
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ENABLE:   cfg_enable   = value[0];
            CFG_ON_TIME:  cfg_on_time  = value;
            CFG_RECOVERY: cfg_recovery = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic en, logic [7:0] on, logic [7:0] rec);
        quiesce();
        cfg_write(CFG_ENABLE, {7'd0, en});
        cfg_write(CFG_ON_TIME, on);
        cfg_write(CFG_RECOVERY, rec);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_directed_cases();
        // disabled after reset: scans ignored, ticks only count
        send_item(make_item(ACT_SCAN, 5'd1, 8'h00, 8'hff));
        send_item(make_item(ACT_TICK, 5'd0, 8'h00, 8'h00));
        send_item(make_item(t_action'(ACT_UNUSED), 5'd31, 8'hff, 8'hff));
        send_item(make_item(ACT_CLEAR, 5'd0, 8'h00, 8'h00));
        set_config(1'b1, 8'd3, 8'd6);
        // byte 0 drops its low nibble
        send_item(make_item(ACT_SCAN, 5'd0, 8'h00, 8'hff));
        send_item(make_item(ACT_SCAN, 5'd0, 8'hff, 8'h0f));
        send_item(make_item(ACT_SCAN, 5'd27, 8'h0f, 8'hff));
        send_item(make_item(ACT_SCAN, 5'd28, 8'h00, 8'hff));
        send_item(make_item(ACT_SCAN, 5'd31, 8'h00, 8'hff));
        send_item(make_item(ACT_SCAN, 5'd5, 8'hff, 8'h00));
        send_item(make_item(t_action'(ACT_UNUSED), 5'd0, 8'h00, 8'h00));
        repeat (11) send_item(make_item(ACT_TICK, 5'd0, 8'h00, 8'h00));
        send_item(make_item(ACT_CLEAR, 5'd31, 8'hff, 8'hff));
        send_item(make_item(ACT_TICK, 5'd0, 8'h00, 8'h00));
    endtask

    task automatic test_counter_saturation();
        set_config(1'b1, 8'd0, 8'd254);
        send_item(make_item(ACT_CLEAR, 5'd0, 8'h00, 8'h00));
        repeat (300) send_item(make_item(ACT_TICK, 5'd0, 8'h00, 8'h00));
        send_item(make_item(ACT_SCAN, 5'd3, 8'h00, 8'h0f));
        repeat (10) send_item(make_item(ACT_TICK, 5'd0, 8'h00, 8'h00));
    endtask

    task automatic test_queue_saturation();
        set_config(1'b1, 8'd1, 8'd250);
        send_item(make_item(ACT_CLEAR, 5'd0, 8'h00, 8'h00));
        repeat (34) send_item(make_item(ACT_SCAN, 5'($urandom_range(1, SCAN_BYTES - 1)),
                                        8'h00, 8'hff));
        repeat (5) send_item(make_item(ACT_TICK, 5'd0, 8'h00, 8'h00));
        send_item(make_item(ACT_CLEAR, 5'd0, 8'h00, 8'h00));
    endtask

    task automatic test_back_to_back();
        set_config(1'b1, 8'd2, 8'd4);
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (200) send_item(random_item());
        tx_gaps_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_config(1'b1, 8'd1, 8'd3);
        tx_gaps_on   = 1'b0;
        hold_tickets = hold_tickets + 1;
        repeat (60) send_item(random_item());
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        int on;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: set_config(1'b1, 8'd0, 8'd0);
                1: set_config(1'b1, 8'd255, 8'd255);
                2: set_config(1'b1, 8'd0, 8'd255);
                3: set_config(1'b1, 8'd255, 8'd0);
                4: set_config(1'b0, 8'($urandom), 8'($urandom));
                default: begin
                    on = $urandom_range(1, 8);
                    set_config($urandom_range(0, 9) != 0, 8'(on),
                               8'(on + $urandom_range(0, 8)));
                end
            endcase
            repeat (110) send_item(random_item());
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_tickets != hold_seen) begin
            hold_seen = hold_tickets;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left   = hold_left - 1;
        end else if (rx_idle_on) begin
            i_out_ready = ($urandom_range(0, 99) >= 28);
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: %h", o_out_data);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.solenoid_drive !== want.solenoid_drive) begin
                    $error("solenoid_drive: expected %0d, got %0d",
                           want.solenoid_drive, o_out_data.solenoid_drive);
                    mismatches++;
                end
                if (o_out_data.scan_request !== want.scan_request) begin
                    $error("scan_request: expected %0d, got %0d",
                           want.scan_request, o_out_data.scan_request);
                    mismatches++;
                end
                if (o_out_data.pending_strikes !== want.pending_strikes) begin
                    $error("pending_strikes: expected %0d, got %0d",
                           want.pending_strikes, o_out_data.pending_strikes);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_cases();
        test_counter_saturation();
        test_queue_saturation();
        test_back_to_back();
        test_output_backpressure();
        test_random_phases();
        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
